// File: rtl/kalman_angle_rate_bias_top_defines.svh
// ----------------------------------------------------------------------------
// kalman_angle_rate_bias_top_defines
// Assertion macros shared by the Kalman angle/rate/bias filter.
// ----------------------------------------------------------------------------
`ifndef KALMAN_ANGLE_RATE_BIAS_TOP_DEFINES_SVH
`define KALMAN_ANGLE_RATE_BIAS_TOP_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define KARB_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define KARB_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/karb_pkg.sv
// ----------------------------------------------------------------------------
// karb_pkg
// Types, constants, storage map and sequencer program of the Kalman filter.
// ----------------------------------------------------------------------------
`default_nettype none

package karb_pkg;

    // storage word and accumulator widths
    localparam int DW     = 50;
    localparam int ACC_W  = 104;
    localparam int NUM_W  = 128;
    localparam int PROD_W = 102;
    localparam int CHUNK  = 17;
    localparam int MB_W   = 51;
    localparam int NUM_CFG = 6;

    typedef logic [5:0] addr_t;
    typedef logic [7:0] pc_t;

    typedef struct packed {
        logic signed [31:0] meas_angle;
        logic signed [31:0] meas_rate;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] est_angle;
        logic signed [31:0] est_rate;
        logic signed [31:0] est_bias;
        logic               singular;
    } out_item_t;

    typedef enum logic [3:0] {
        OP_CLR, OP_BASE, OP_MAC, OP_FIX, OP_DET,
        OP_DIV, OP_COPY, OP_Y, OP_LOAD, OP_SEND
    } op_t;

    typedef struct packed {
        op_t        op;
        logic       neg;
        addr_t      ra;
        addr_t      rb;
        addr_t      wd;
        logic [1:0] sel;
    } instr_t;

    // storage map
    localparam addr_t A_DT  = 6'd0;
    localparam addr_t A_QA  = 6'd1;
    localparam addr_t A_QR  = 6'd2;
    localparam addr_t A_QB  = 6'd3;
    localparam addr_t A_RA  = 6'd4;
    localparam addr_t A_RR  = 6'd5;
    localparam addr_t A_ONE = 6'd6;
    localparam addr_t A_X0  = 6'd8;
    localparam addr_t A_X1  = 6'd9;
    localparam addr_t A_X2  = 6'd10;
    localparam addr_t A_P0  = 6'd16;
    localparam addr_t A_P1  = 6'd17;
    localparam addr_t A_P2  = 6'd18;
    localparam addr_t A_P3  = 6'd19;
    localparam addr_t A_P4  = 6'd20;
    localparam addr_t A_P5  = 6'd21;
    localparam addr_t A_P6  = 6'd22;
    localparam addr_t A_P7  = 6'd23;
    localparam addr_t A_P8  = 6'd24;
    localparam addr_t A_TA  = 6'd32;
    localparam addr_t A_TB  = 6'd33;
    localparam addr_t A_TC  = 6'd34;
    localparam addr_t A_Y1  = 6'd35;
    localparam addr_t A_Y2  = 6'd36;
    localparam addr_t A_S11 = 6'd37;
    localparam addr_t A_S22 = 6'd38;
    localparam addr_t A_K11 = 6'd40;
    localparam addr_t A_K12 = 6'd41;
    localparam addr_t A_K21 = 6'd42;
    localparam addr_t A_K22 = 6'd43;
    localparam addr_t A_K31 = 6'd44;
    localparam addr_t A_K32 = 6'd45;
    localparam addr_t A_N0  = 6'd48;
    localparam addr_t A_N1  = 6'd49;
    localparam addr_t A_N2  = 6'd50;
    localparam addr_t A_N3  = 6'd51;
    localparam addr_t A_N4  = 6'd52;
    localparam addr_t A_N5  = 6'd53;
    localparam addr_t A_N6  = 6'd54;
    localparam addr_t A_N7  = 6'd55;
    localparam addr_t A_N8  = 6'd56;

    localparam logic [1:0] SEL_ANGLE = 2'd0;
    localparam logic [1:0] SEL_RATE  = 2'd1;
    localparam logic [1:0] SEL_BIAS  = 2'd2;

    localparam pc_t PC_OUT  = 8'd130;
    localparam pc_t PC_LAST = 8'd133;

    localparam logic signed [DW-1:0] ONE_Q24   = 50'sd16777216;
    localparam logic signed [DW-1:0] P_INIT    = 50'sd16777216000;
    localparam logic signed [DW-1:0] Q48_MAX   = 50'sd140737488355327;
    localparam logic signed [DW-1:0] Q48_MIN   = -50'sd140737488355328;

    // value of a storage word that has never been written
    function automatic logic signed [DW-1:0] rst_val(input addr_t a);
        logic signed [DW-1:0] r;
        unique case (a)
            A_DT:                r = 50'sd167772;
            A_QA:                r = 50'sd16777;
            A_QR, A_QB:          r = 50'sd50332;
            A_RA, A_RR:          r = 50'sd503316;
            A_ONE:               r = ONE_Q24;
            A_P0, A_P4, A_P8:    r = P_INIT;
            default:             r = '0;
        endcase
        return r;
    endfunction

    function automatic instr_t mk(input op_t op, input logic neg, input addr_t ra,
                                  input addr_t rb, input addr_t wd, input logic [1:0] sel);
        instr_t r;
        r.op  = op;
        r.neg = neg;
        r.ra  = ra;
        r.rb  = rb;
        r.wd  = wd;
        r.sel = sel;
        return r;
    endfunction

    function automatic instr_t i_clr();
        return mk(OP_CLR, 1'b0, '0, '0, '0, '0);
    endfunction
    function automatic instr_t i_base(input addr_t a);
        return mk(OP_BASE, 1'b0, a, '0, '0, '0);
    endfunction
    function automatic instr_t i_mac(input addr_t a, input addr_t b);
        return mk(OP_MAC, 1'b0, a, b, '0, '0);
    endfunction
    function automatic instr_t i_msb(input addr_t a, input addr_t b);
        return mk(OP_MAC, 1'b1, a, b, '0, '0);
    endfunction
    function automatic instr_t i_fix(input addr_t w);
        return mk(OP_FIX, 1'b0, '0, '0, w, '0);
    endfunction
    function automatic instr_t i_det();
        return mk(OP_DET, 1'b0, '0, '0, '0, '0);
    endfunction
    function automatic instr_t i_div(input addr_t w);
        return mk(OP_DIV, 1'b0, '0, '0, w, '0);
    endfunction
    function automatic instr_t i_copy(input addr_t a, input addr_t w);
        return mk(OP_COPY, 1'b0, a, '0, w, '0);
    endfunction
    function automatic instr_t i_y(input addr_t a, input logic [1:0] s, input addr_t w);
        return mk(OP_Y, 1'b0, a, '0, w, s);
    endfunction
    function automatic instr_t i_load(input addr_t a, input logic [1:0] s);
        return mk(OP_LOAD, 1'b0, a, '0, '0, s);
    endfunction
    function automatic instr_t i_send();
        return mk(OP_SEND, 1'b0, '0, '0, '0, '0);
    endfunction

    // sequencer program: predict, innovation, gain, correct, emit
    function automatic instr_t ucode(input pc_t pc);
        instr_t r;
        unique case (pc)
            // predict angle
            8'd0:   r = i_base(A_X0);
            8'd1:   r = i_mac(A_DT, A_X1);
            8'd2:   r = i_msb(A_DT, A_X2);
            8'd3:   r = i_fix(A_X0);
            // intermediate row terms
            8'd4:   r = i_base(A_P0);
            8'd5:   r = i_mac(A_P3, A_DT);
            8'd6:   r = i_msb(A_P6, A_DT);
            8'd7:   r = i_fix(A_TA);
            8'd8:   r = i_base(A_P1);
            8'd9:   r = i_mac(A_P4, A_DT);
            8'd10:  r = i_msb(A_P7, A_DT);
            8'd11:  r = i_fix(A_TB);
            8'd12:  r = i_base(A_P2);
            8'd13:  r = i_mac(A_P5, A_DT);
            8'd14:  r = i_msb(A_P8, A_DT);
            8'd15:  r = i_fix(A_TC);
            // predicted covariance
            8'd16:  r = i_base(A_TA);
            8'd17:  r = i_mac(A_QA, A_ONE);
            8'd18:  r = i_mac(A_TB, A_DT);
            8'd19:  r = i_msb(A_TC, A_DT);
            8'd20:  r = i_fix(A_P0);
            8'd21:  r = i_copy(A_TB, A_P1);
            8'd22:  r = i_copy(A_TC, A_P2);
            8'd23:  r = i_base(A_P3);
            8'd24:  r = i_mac(A_P4, A_DT);
            8'd25:  r = i_msb(A_P5, A_DT);
            8'd26:  r = i_fix(A_P3);
            8'd27:  r = i_base(A_P4);
            8'd28:  r = i_mac(A_QR, A_ONE);
            8'd29:  r = i_fix(A_P4);
            8'd30:  r = i_base(A_P6);
            8'd31:  r = i_mac(A_P7, A_DT);
            8'd32:  r = i_msb(A_P8, A_DT);
            8'd33:  r = i_fix(A_P6);
            8'd34:  r = i_base(A_P8);
            8'd35:  r = i_mac(A_QB, A_ONE);
            8'd36:  r = i_fix(A_P8);
            // innovation and its covariance
            8'd37:  r = i_y(A_X0, SEL_ANGLE, A_Y1);
            8'd38:  r = i_y(A_X1, SEL_RATE, A_Y2);
            8'd39:  r = i_base(A_P0);
            8'd40:  r = i_mac(A_RA, A_ONE);
            8'd41:  r = i_fix(A_S11);
            8'd42:  r = i_base(A_P4);
            8'd43:  r = i_mac(A_RR, A_ONE);
            8'd44:  r = i_fix(A_S22);
            8'd45:  r = i_clr();
            8'd46:  r = i_mac(A_S11, A_S22);
            8'd47:  r = i_msb(A_P1, A_P3);
            8'd48:  r = i_det();
            // gains
            8'd49:  r = i_clr();
            8'd50:  r = i_mac(A_P0, A_S22);
            8'd51:  r = i_msb(A_P1, A_P3);
            8'd52:  r = i_div(A_K11);
            8'd53:  r = i_clr();
            8'd54:  r = i_mac(A_P1, A_S11);
            8'd55:  r = i_msb(A_P0, A_P1);
            8'd56:  r = i_div(A_K12);
            8'd57:  r = i_clr();
            8'd58:  r = i_mac(A_P3, A_S22);
            8'd59:  r = i_msb(A_P4, A_P3);
            8'd60:  r = i_div(A_K21);
            8'd61:  r = i_clr();
            8'd62:  r = i_mac(A_P4, A_S11);
            8'd63:  r = i_msb(A_P3, A_P1);
            8'd64:  r = i_div(A_K22);
            8'd65:  r = i_clr();
            8'd66:  r = i_mac(A_P6, A_S22);
            8'd67:  r = i_msb(A_P7, A_P3);
            8'd68:  r = i_div(A_K31);
            8'd69:  r = i_clr();
            8'd70:  r = i_mac(A_P7, A_S11);
            8'd71:  r = i_msb(A_P6, A_P1);
            8'd72:  r = i_div(A_K32);
            // state correction
            8'd73:  r = i_base(A_X0);
            8'd74:  r = i_mac(A_K11, A_Y1);
            8'd75:  r = i_mac(A_K12, A_Y2);
            8'd76:  r = i_fix(A_X0);
            8'd77:  r = i_base(A_X1);
            8'd78:  r = i_mac(A_K21, A_Y1);
            8'd79:  r = i_mac(A_K22, A_Y2);
            8'd80:  r = i_fix(A_X1);
            8'd81:  r = i_base(A_X2);
            8'd82:  r = i_mac(A_K31, A_Y1);
            8'd83:  r = i_mac(A_K32, A_Y2);
            8'd84:  r = i_fix(A_X2);
            // covariance correction into scratch, then copied back into P
            8'd85:  r = i_base(A_P0);
            8'd86:  r = i_msb(A_P0, A_K11);
            8'd87:  r = i_msb(A_P3, A_K12);
            8'd88:  r = i_fix(A_N0);
            8'd89:  r = i_base(A_P1);
            8'd90:  r = i_msb(A_P1, A_K11);
            8'd91:  r = i_msb(A_P4, A_K12);
            8'd92:  r = i_fix(A_N1);
            8'd93:  r = i_base(A_P2);
            8'd94:  r = i_msb(A_P2, A_K11);
            8'd95:  r = i_msb(A_P5, A_K12);
            8'd96:  r = i_fix(A_N2);
            8'd97:  r = i_base(A_P3);
            8'd98:  r = i_msb(A_P3, A_K22);
            8'd99:  r = i_msb(A_P0, A_K21);
            8'd100: r = i_fix(A_N3);
            8'd101: r = i_base(A_P4);
            8'd102: r = i_msb(A_P4, A_K22);
            8'd103: r = i_msb(A_P1, A_K21);
            8'd104: r = i_fix(A_N4);
            8'd105: r = i_base(A_P5);
            8'd106: r = i_msb(A_P5, A_K22);
            8'd107: r = i_msb(A_P2, A_K21);
            8'd108: r = i_fix(A_N5);
            8'd109: r = i_base(A_P6);
            8'd110: r = i_msb(A_P3, A_K32);
            8'd111: r = i_msb(A_P0, A_K31);
            8'd112: r = i_fix(A_N6);
            8'd113: r = i_base(A_P7);
            8'd114: r = i_msb(A_P4, A_K32);
            8'd115: r = i_msb(A_P1, A_K31);
            8'd116: r = i_fix(A_N7);
            8'd117: r = i_base(A_P8);
            8'd118: r = i_msb(A_P5, A_K32);
            8'd119: r = i_msb(A_P2, A_K31);
            8'd120: r = i_fix(A_N8);
            8'd121: r = i_copy(A_N0, A_P0);
            8'd122: r = i_copy(A_N1, A_P1);
            8'd123: r = i_copy(A_N2, A_P2);
            8'd124: r = i_copy(A_N3, A_P3);
            8'd125: r = i_copy(A_N4, A_P4);
            8'd126: r = i_copy(A_N5, A_P5);
            8'd127: r = i_copy(A_N6, A_P6);
            8'd128: r = i_copy(A_N7, A_P7);
            8'd129: r = i_copy(A_N8, A_P8);
            // emit
            8'd130: r = i_load(A_X0, SEL_ANGLE);
            8'd131: r = i_load(A_X1, SEL_RATE);
            8'd132: r = i_load(A_X2, SEL_BIAS);
            default: r = i_send();
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/kalman_angle_rate_bias_top.sv
// ----------------------------------------------------------------------------
// kalman_angle_rate_bias_top
// Three-state Kalman filter (angle, rate, gyro bias) run by a microcoded
// sequencer over one shared multiplier, one accumulator and a serial divider.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  in        sink       in_valid / in_stall  in_data   (meas_angle, meas_rate)
//  out       source     out_valid/ out_stall out_data  (estimates, singular)
//  cfg       sink       cfg_we               cfg_index, cfg_data
//
//  An item skips the gains and the correction when the innovation covariance
//  is singular. The work is 57 multiply-accumulates on the 50x17 bit
//  multiplier, six divisions of 128 restoring steps each and the scratch
//  store with one read and one write port. in_stall is high from the
//  transfer of an item until its result is staged; a stalled earlier
//  result holds the staging.
//  Reset restores registers and covariance through per-word valid bits.
// ----------------------------------------------------------------------------
`default_nettype none
`include "kalman_angle_rate_bias_top_defines.svh"

module kalman_angle_rate_bias_top (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire karb_pkg::in_item_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output karb_pkg::out_item_t      out_data,
    input  wire logic                cfg_we,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [31:0]         cfg_data
);
    import karb_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_DEC, S_RDA, S_RDB, S_MUL, S_ACC, S_DIV, S_DIVW
    } state_t;

    localparam logic signed [ACC_W-1:0] ACC_HALF = 104'sd8388608;
    localparam logic signed [ACC_W-1:0] ACC_QMAX = 104'sd140737488355327;
    localparam logic signed [ACC_W-1:0] ACC_QMIN = -104'sd140737488355328;
    localparam logic signed [DW:0]      OUT_MAX  = 51'sd2147483647;
    localparam logic signed [DW:0]      OUT_MIN  = -51'sd2147483648;

    // round Q48.48 to Q24.24 and clamp to 48 bits
    function automatic logic signed [DW-1:0] fix_q(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] t;
        logic signed [DW-1:0]    r;
        t = (v + ACC_HALF) >>> 24;
        if (t > ACC_QMAX)      r = Q48_MAX;
        else if (t < ACC_QMIN) r = Q48_MIN;
        else                   r = t[DW-1:0];
        return r;
    endfunction

    // round Q24.24 to Q16.16 and clamp to 32 bits
    function automatic logic [31:0] to_q16(input logic signed [DW-1:0] x);
        logic signed [DW:0] t;
        logic [31:0]        r;
        t = ($signed({x[DW-1], x}) + 51'sd128) >>> 8;
        if (t > OUT_MAX)      r = 32'h7FFF_FFFF;
        else if (t < OUT_MIN) r = 32'h8000_0000;
        else                  r = t[31:0];
        return r;
    endfunction

    state_t                  state_reg;
    pc_t                     pc_reg;
    instr_t                  ins;
    in_item_t                meas_reg;
    logic                    sing_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] det_reg;
    logic signed [DW-1:0]    opa_reg;
    logic [DW-1:0]           ma_reg;
    logic [MB_W-1:0]         mb_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic                    pneg_reg;
    logic [1:0]              chunk_reg;
    logic [NUM_W-1:0]        n_reg;
    logic [ACC_W-1:0]        d_reg;
    logic [ACC_W-1:0]        r_reg;
    logic [47:0]             q_reg;
    logic                    ovf_reg;
    logic                    dneg_reg;
    logic [6:0]              cnt_reg;
    logic [31:0]             st_angle_reg;
    logic [31:0]             st_rate_reg;
    logic [31:0]             st_bias_reg;
    logic                    out_valid_reg;
    out_item_t               out_data_reg;

    // scratch store
    logic signed [DW-1:0]    mem [64];
    logic [63:0]             vld_reg;
    logic signed [DW-1:0]    rdata_reg;
    addr_t                   raddr;
    logic                    we;
    addr_t                   waddr;
    logic signed [DW-1:0]    wdata;

    // datapath helpers
    logic signed [DW-1:0]    rd_neg;
    logic [DW-1:0]           b_mag;
    logic [DW-1:0]           a_mag;
    logic [DW+CHUNK-1:0]     pp;
    logic [ACC_W-1:0]        num_mag;
    logic [ACC_W-1:0]        det_mag;
    logic [ACC_W:0]          rs;
    logic                    ge;
    logic [ACC_W:0]          rs_sub;
    logic signed [DW-1:0]    div_res;
    logic signed [DW-1:0]    y_val;
    logic signed [31:0]      meas_sel;
    logic                    out_free;

    assign ins      = ucode(pc_reg);
    assign raddr    = (state_reg == S_RDA) ? ins.rb : ins.ra;
    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    // operand magnitudes and one partial product
    assign rd_neg  = -rdata_reg;
    assign b_mag   = rdata_reg[DW-1] ? rd_neg : rdata_reg;
    assign a_mag   = opa_reg[DW-1] ? -opa_reg : opa_reg;
    assign pp      = ma_reg * mb_reg[MB_W-1 -: CHUNK];
    assign num_mag = acc_reg[ACC_W-1] ? -acc_reg : acc_reg;
    assign det_mag = det_reg[ACC_W-1] ? -det_reg : det_reg;

    // one restoring division step
    assign rs     = {r_reg, n_reg[NUM_W-1]};
    assign rs_sub = rs - {1'b0, d_reg};
    assign ge     = (rs >= {1'b0, d_reg});

    // saturate the quotient
    always_comb
    begin
        if (!dneg_reg) begin
            div_res = (ovf_reg || q_reg[47]) ? Q48_MAX : $signed({2'b00, q_reg});
        end else if (ovf_reg || (q_reg[47] && (|q_reg[46:0]))) begin
            div_res = Q48_MIN;
        end else begin
            div_res = -$signed({2'b00, q_reg});
        end
    end

    // innovation: measurement in Q24.24 minus prediction
    assign meas_sel = (ins.sel == SEL_ANGLE) ? meas_reg.meas_angle : meas_reg.meas_rate;
    assign y_val    = $signed({{(DW-40){meas_sel[31]}}, meas_sel, 8'b0}) - rdata_reg;

    // write port: configuration while idle, otherwise the sequencer
    always_comb
    begin
        we    = 1'b0;
        waddr = addr_t'(cfg_index);
        wdata = $signed({{(DW-32){1'b0}}, cfg_data});
        priority case (state_reg)
            S_IDLE:
            begin
                we = cfg_we && (cfg_index < 3'(NUM_CFG));
            end
            S_DEC:
            begin
                if (ins.op == OP_FIX) begin
                    we    = 1'b1;
                    waddr = ins.wd;
                    wdata = fix_q(acc_reg);
                end
            end
            S_RDA:
            begin
                if (ins.op == OP_COPY) begin
                    we    = 1'b1;
                    waddr = ins.wd;
                    wdata = rdata_reg;
                end else if (ins.op == OP_Y) begin
                    we    = 1'b1;
                    waddr = ins.wd;
                    wdata = y_val;
                end
            end
            S_DIVW:
            begin
                we    = 1'b1;
                waddr = ins.wd;
                wdata = div_res;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    // store array and registered read
    always_ff @(posedge clk)
    begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= vld_reg[raddr] ? mem[raddr] : rst_val(raddr);
    end

    // mark words as written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= '0;
        end else if (we) begin
            vld_reg[waddr] <= 1'b1;
        end
    end

    // sequencer and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            pc_reg        <= '0;
            sing_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            meas_reg      <= '0;
            acc_reg       <= '0;
            det_reg       <= '0;
            opa_reg       <= '0;
            ma_reg        <= '0;
            mb_reg        <= '0;
            prod_reg      <= '0;
            pneg_reg      <= 1'b0;
            chunk_reg     <= '0;
            n_reg         <= '0;
            d_reg         <= '0;
            r_reg         <= '0;
            q_reg         <= '0;
            ovf_reg       <= 1'b0;
            dneg_reg      <= 1'b0;
            cnt_reg       <= '0;
            st_angle_reg  <= '0;
            st_rate_reg   <= '0;
            st_bias_reg   <= '0;
            out_data_reg  <= '0;
        end else begin
            // drop the result once transferred, unless a new one is staged
            if (out_valid_reg && !out_stall &&
                !(state_reg == S_DEC && ins.op == OP_SEND)) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid) begin
                        meas_reg  <= in_data;
                        pc_reg    <= '0;
                        sing_reg  <= 1'b0;
                        state_reg <= S_DEC;
                    end
                end
                S_DEC:
                begin
                    unique case (ins.op)
                        OP_CLR:
                        begin
                            acc_reg <= '0;
                            pc_reg  <= pc_reg + 8'd1;
                        end
                        OP_FIX:
                        begin
                            pc_reg <= pc_reg + 8'd1;
                        end
                        OP_DET:
                        begin
                            det_reg <= acc_reg;
                            if (acc_reg == '0) begin
                                sing_reg <= 1'b1;
                                pc_reg   <= PC_OUT;
                            end else begin
                                pc_reg <= pc_reg + 8'd1;
                            end
                        end
                        OP_DIV:
                        begin
                            n_reg     <= {num_mag, 24'b0};
                            d_reg     <= det_mag;
                            r_reg     <= '0;
                            q_reg     <= '0;
                            ovf_reg   <= 1'b0;
                            dneg_reg  <= acc_reg[ACC_W-1] ^ det_reg[ACC_W-1];
                            cnt_reg   <= 7'(NUM_W - 1);
                            state_reg <= S_DIV;
                        end
                        OP_SEND:
                        begin
                            if (out_free) begin
                                out_data_reg.est_angle <= st_angle_reg;
                                out_data_reg.est_rate  <= st_rate_reg;
                                out_data_reg.est_bias  <= st_bias_reg;
                                out_data_reg.singular  <= sing_reg;
                                out_valid_reg          <= 1'b1;
                                state_reg              <= S_IDLE;
                            end
                        end
                        default:
                        begin
                            state_reg <= S_RDA;
                        end
                    endcase
                end
                S_RDA:
                begin
                    unique case (ins.op)
                        OP_BASE:
                        begin
                            acc_reg   <= $signed({{(ACC_W-DW-24){rdata_reg[DW-1]}},
                                                  rdata_reg, 24'b0});
                            pc_reg    <= pc_reg + 8'd1;
                            state_reg <= S_DEC;
                        end
                        OP_MAC:
                        begin
                            opa_reg   <= rdata_reg;
                            state_reg <= S_RDB;
                        end
                        OP_LOAD:
                        begin
                            case (ins.sel)
                                SEL_ANGLE: st_angle_reg <= to_q16(rdata_reg);
                                SEL_RATE:  st_rate_reg  <= to_q16(rdata_reg);
                                default:   st_bias_reg  <= to_q16(rdata_reg);
                            endcase
                            pc_reg    <= pc_reg + 8'd1;
                            state_reg <= S_DEC;
                        end
                        default:
                        begin
                            pc_reg    <= pc_reg + 8'd1;
                            state_reg <= S_DEC;
                        end
                    endcase
                end
                S_RDB:
                begin
                    ma_reg    <= a_mag;
                    mb_reg    <= {1'b0, b_mag};
                    pneg_reg  <= opa_reg[DW-1] ^ rdata_reg[DW-1] ^ ins.neg;
                    prod_reg  <= '0;
                    chunk_reg <= '0;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    // advance one 17-bit digit of the multiplier, top first
                    prod_reg  <= (prod_reg << CHUNK) + PROD_W'(pp);
                    mb_reg    <= mb_reg << CHUNK;
                    chunk_reg <= chunk_reg + 2'd1;
                    if (chunk_reg == 2'd2) begin
                        state_reg <= S_ACC;
                    end
                end
                S_ACC:
                begin
                    if (pneg_reg) acc_reg <= acc_reg - $signed(ACC_W'(prod_reg));
                    else          acc_reg <= acc_reg + $signed(ACC_W'(prod_reg));
                    pc_reg    <= pc_reg + 8'd1;
                    state_reg <= S_DEC;
                end
                S_DIV:
                begin
                    r_reg   <= ge ? rs_sub[ACC_W-1:0] : rs[ACC_W-1:0];
                    q_reg   <= {q_reg[46:0], ge};
                    ovf_reg <= ovf_reg | q_reg[47];
                    n_reg   <= n_reg << 1;
                    if (cnt_reg == '0) begin
                        state_reg <= S_DIVW;
                    end else begin
                        cnt_reg <= cnt_reg - 7'd1;
                    end
                end
                S_DIVW:
                begin
                    pc_reg    <= pc_reg + 8'd1;
                    state_reg <= S_DEC;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `KARB_NEXT(a_busy_after_accept, in_valid && !in_stall, state_reg != S_IDLE, "item not started")
    `KARB_SAME(a_div_nonzero, state_reg == S_DIV, d_reg != '0, "division by zero determinant")
    `KARB_SAME(a_pc_in_program, state_reg != S_IDLE, pc_reg <= PC_LAST, "sequencer ran off program")

endmodule

`default_nettype wire

// File: verif/kalman_angle_rate_bias_top_tb.sv
// ----------------------------------------------------------------------------
// kalman_angle_rate_bias_top_tb
// Self-checking bench for the three-state Kalman filter. A directed table is
// run at reset settings, then random measurement sequences under several
// register settings and idle/stall mixes; each result is checked against a
// typed value or an in-bench fixed-point filter with the block's rounding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kalman_angle_rate_bias_top_tb;

    import karb_pkg::*;

    typedef logic signed [159:0] wide_t;
    typedef logic signed [63:0]  q_t;

    localparam q_t Q48_HI = (64'sd1 <<< 47) - 1;
    localparam q_t Q48_LO = -(64'sd1 <<< 47);
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 1700;
    localparam int RAND_PER_PHASE = 85;

    // register indexes
    localparam logic [2:0] REG_TIME_STEP   = 3'd0;
    localparam logic [2:0] REG_ANGLE_QN    = 3'd1;
    localparam logic [2:0] REG_RATE_QN     = 3'd2;
    localparam logic [2:0] REG_BIAS_QN     = 3'd3;
    localparam logic [2:0] REG_ANGLE_RN    = 3'd4;
    localparam logic [2:0] REG_RATE_RN     = 3'd5;
    localparam logic [2:0] REG_SPARE_LO    = 3'd6;
    localparam logic [2:0] REG_SPARE_HI    = 3'd7;
    localparam int         NUM_REGS        = 6;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_stall;
    out_item_t   out_data;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    kalman_angle_rate_bias_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // filter state mirrored by the bench
    q_t        est_x [3];
    q_t        est_p [9];
    q_t        reg_val [NUM_REGS];
    out_item_t estimate_q [$];

    logic      in_taken;
    int        errors;
    int        quiet_cycles;
    int        stall_pct;
    logic      use_typed;
    out_item_t typed_result;

    function automatic q_t sat48(wide_t v);
        if (v > wide_t'(Q48_HI))
            return Q48_HI;
        if (v < wide_t'(Q48_LO))
            return Q48_LO;
        return q_t'(v);
    endfunction

    function automatic wide_t prod(q_t a, q_t b);
        return wide_t'(a) * wide_t'(b);
    endfunction

    // base + a*b - c*d exact at Q48.48, rounded once to Q24.24
    function automatic q_t fma2(q_t base, q_t a, q_t b, q_t c, q_t d);
        wide_t w;
        w = (wide_t'(base) <<< 24) + prod(a, b) - prod(c, d);
        return sat48((w + wide_t'(64'sd8388608)) >>> 24);
    endfunction

    function automatic q_t gain(wide_t num, wide_t den);
        return sat48((num <<< 24) / den);
    endfunction

    function automatic logic signed [31:0] to_q16(q_t x);
        q_t r;
        r = (x + 64'sd128) >>> 8;
        if (r > q_t'(32'sh7fffffff))
            return 32'sh7fffffff;
        if (r < -q_t'(64'sd2147483648))
            return 32'sh80000000;
        return r[31:0];
    endfunction

    function automatic void filter_reset();
        for (int i = 0; i < 3; i++)
            est_x[i] = '0;
        for (int i = 0; i < 9; i++)
            est_p[i] = (i % 4 == 0) ? (64'sd1000 <<< 24) : '0;
        reg_val[REG_TIME_STEP] = 64'sd167772;
        reg_val[REG_ANGLE_QN]  = 64'sd16777;
        reg_val[REG_RATE_QN]   = 64'sd50332;
        reg_val[REG_BIAS_QN]   = 64'sd50332;
        reg_val[REG_ANGLE_RN]  = 64'sd503316;
        reg_val[REG_RATE_RN]   = 64'sd503316;
    endfunction

    // one predict/correct step; returns the emitted estimates
    function automatic out_item_t filter_step(in_item_t m);
        q_t        dt, ta, tb, tc, y1, y2, s11, s12, s21, s22;
        q_t        k11, k12, k21, k22, k31, k32;
        q_t        nx [9];
        wide_t     det;
        out_item_t r;
        dt = reg_val[REG_TIME_STEP];

        est_x[0] = fma2(est_x[0], dt, est_x[1], dt, est_x[2]);
        ta = fma2(est_p[0], est_p[3], dt, est_p[6], dt);
        tb = fma2(est_p[1], est_p[4], dt, est_p[7], dt);
        tc = fma2(est_p[2], est_p[5], dt, est_p[8], dt);
        est_p[0] = fma2(ta + reg_val[REG_ANGLE_QN], tb, dt, tc, dt);
        est_p[1] = tb;
        est_p[2] = tc;
        est_p[3] = fma2(est_p[3], est_p[4], dt, est_p[5], dt);
        est_p[4] = sat48(wide_t'(est_p[4] + reg_val[REG_RATE_QN]));
        est_p[6] = fma2(est_p[6], est_p[7], dt, est_p[8], dt);
        est_p[8] = sat48(wide_t'(est_p[8] + reg_val[REG_BIAS_QN]));

        y1 = q_t'(m.meas_angle) * 256 - est_x[0];
        y2 = q_t'(m.meas_rate) * 256 - est_x[1];
        s11 = sat48(wide_t'(est_p[0] + reg_val[REG_ANGLE_RN]));
        s12 = est_p[1];
        s21 = est_p[3];
        s22 = sat48(wide_t'(est_p[4] + reg_val[REG_RATE_RN]));
        det = prod(s11, s22) - prod(s12, s21);
        r.singular = (det == 0);

        // skip the correction when the innovation covariance is singular
        if (!r.singular)
        begin
            k11 = gain(prod(est_p[0], s22) - prod(est_p[1], s21), det);
            k12 = gain(prod(est_p[1], s11) - prod(est_p[0], s12), det);
            k21 = gain(prod(est_p[3], s22) - prod(est_p[4], s21), det);
            k22 = gain(prod(est_p[4], s11) - prod(est_p[3], s12), det);
            k31 = gain(prod(est_p[6], s22) - prod(est_p[7], s21), det);
            k32 = gain(prod(est_p[7], s11) - prod(est_p[6], s12), det);

            est_x[0] = fma2(est_x[0], k11, y1, k12, -y2);
            est_x[1] = fma2(est_x[1], k21, y1, k22, -y2);
            est_x[2] = fma2(est_x[2], k31, y1, k32, -y2);

            nx[0] = fma2(est_p[0], est_p[0], -k11, est_p[3], k12);
            nx[1] = fma2(est_p[1], est_p[1], -k11, est_p[4], k12);
            nx[2] = fma2(est_p[2], est_p[2], -k11, est_p[5], k12);
            nx[3] = fma2(est_p[3], est_p[3], -k22, est_p[0], k21);
            nx[4] = fma2(est_p[4], est_p[4], -k22, est_p[1], k21);
            nx[5] = fma2(est_p[5], est_p[5], -k22, est_p[2], k21);
            // bias row uses row 2 col 3 on the p33 term, as published
            nx[6] = fma2(est_p[6], est_p[3], -k32, est_p[0], k31);
            nx[7] = fma2(est_p[7], est_p[4], -k32, est_p[1], k31);
            nx[8] = fma2(est_p[8], est_p[5], -k32, est_p[2], k31);
            for (int i = 0; i < 9; i++)
                est_p[i] = nx[i];
        end

        r.est_angle = to_q16(est_x[0]);
        r.est_rate  = to_q16(est_x[1]);
        r.est_bias  = to_q16(est_x[2]);
        return r;
    endfunction

    function automatic void check_result(out_item_t got);
        out_item_t want;
        if (estimate_q.size() == 0)
        begin
            $error("unexpected result transfer: angle %0d rate %0d bias %0d",
                   got.est_angle, got.est_rate, got.est_bias);
            errors++;
            return;
        end
        want = estimate_q.pop_front();
        if (got.est_angle !== want.est_angle)
        begin
            $error("est_angle expected %0d actual %0d", want.est_angle, got.est_angle);
            errors++;
        end
        if (got.est_rate !== want.est_rate)
        begin
            $error("est_rate expected %0d actual %0d", want.est_rate, got.est_rate);
            errors++;
        end
        if (got.est_bias !== want.est_bias)
        begin
            $error("est_bias expected %0d actual %0d", want.est_bias, got.est_bias);
            errors++;
        end
        if (got.singular !== want.singular)
        begin
            $error("singular expected %0d actual %0d", want.singular, got.singular);
            errors++;
        end
    endfunction

    // track transfers at the rising edge: predict, check, mirror writes
    always @(posedge clk)
    begin
        out_item_t predicted;
        if (!rst_n)
        begin
            in_taken <= 1'b0;
            quiet_cycles = 0;
        end
        else
        begin
            in_taken <= in_valid && !in_stall;
            quiet_cycles++;
            if (cfg_we && cfg_index < NUM_REGS)
                reg_val[cfg_index] = q_t'({32'b0, cfg_data});
            if (in_valid && !in_stall)
            begin
                quiet_cycles = 0;
                predicted = filter_step(in_data);
                estimate_q.push_back(use_typed ? typed_result : predicted);
            end
            if (out_valid && !out_stall)
            begin
                quiet_cycles = 0;
                check_result(out_data);
            end
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("kalman_angle_rate_bias_top_tb: done, errors");
                $finish;
            end
        end
    end

    // receiver stalls at random
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic send(in_item_t item, int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(negedge clk);
        while (!in_taken);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (estimate_q.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    // write a full register set while the block is idle
    task automatic write_regs(logic [NUM_REGS-1:0][31:0] vals, logic touch_spare);
        wait_drained();
        cfg_we <= 1'b1;
        for (int i = 0; i < NUM_REGS; i++)
        begin
            cfg_index <= i[2:0];
            cfg_data  <= vals[i];
            @(negedge clk);
        end
        if (touch_spare)
        begin
            cfg_index <= REG_SPARE_LO;
            cfg_data  <= 32'hffffffff;
            @(negedge clk);
            cfg_index <= REG_SPARE_HI;
            cfg_data  <= 32'h0;
            @(negedge clk);
        end
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    function automatic in_item_t random_meas();
        in_item_t m;
        // mostly plausible sensor data, some full-range noise
        if ($urandom_range(99) < 85)
        begin
            m.meas_angle = $signed($urandom_range(32'h200000)) - 32'sh100000;
            m.meas_rate  = $signed($urandom_range(32'h200000)) - 32'sh100000;
        end
        else
        begin
            m.meas_angle = $urandom;
            m.meas_rate  = $urandom;
        end
        return m;
    endfunction

    typedef struct {
        logic signed [31:0] angle;
        logic signed [31:0] rate;
        logic               typed;
        out_item_t          result;
    } stim_row_t;

    stim_row_t directed [] = '{
        // state at reset is zero: zero measurements keep it there
        '{32'sd0, 32'sd0, 1'b1, '{32'sd0, 32'sd0, 32'sd0, 1'b0}},
        '{32'sd0, 32'sd0, 1'b1, '{32'sd0, 32'sd0, 32'sd0, 1'b0}},
        '{32'sd65536, 32'sd0, 1'b0, '0},
        '{32'sd0, 32'sd65536, 1'b0, '0},
        '{32'sh7fffffff, 32'sh7fffffff, 1'b0, '0},
        '{32'sh80000000, 32'sh80000000, 1'b0, '0},
        '{32'sh7fffffff, 32'sh80000000, 1'b0, '0},
        '{32'sh80000000, 32'sh7fffffff, 1'b0, '0},
        '{32'sh55555555, 32'shaaaaaaaa, 1'b0, '0},
        '{32'shaaaaaaaa, 32'sh55555555, 1'b0, '0},
        '{32'sd1, -32'sd1, 1'b0, '0},
        '{-32'sd1, 32'sd1, 1'b0, '0},
        '{32'sd0, 32'sd0, 1'b0, '0},
        '{32'sd131072, -32'sd32768, 1'b0, '0},
        '{-32'sd131072, 32'sd32768, 1'b0, '0},
        '{32'sd0, 32'sd0, 1'b0, '0}
    };

    initial
    begin
        logic [NUM_REGS-1:0][31:0] regs;
        int idle_in;
        in_item_t item;

        filter_reset();
        errors       = 0;
        quiet_cycles = 0;
        stall_pct    = 0;
        use_typed    = 1'b0;
        typed_result = '0;
        in_valid     = 1'b0;
        in_data      = '0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        rst_n        = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed table at reset settings
        foreach (directed[i])
        begin
            use_typed    = directed[i].typed;
            typed_result = directed[i].result;
            item.meas_angle = directed[i].angle;
            item.meas_rate  = directed[i].rate;
            send(item, 0);
        end
        use_typed = 1'b0;

        // random phases over register settings and idle mixes
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: regs = {32'd503316, 32'd503316, 32'd50332, 32'd50332,
                           32'd16777, 32'd167772};
                1: regs = {32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd1};
                2: regs = {32'd1677721, 32'd1677721, 32'd0, 32'd0,
                           32'd0, 32'd0};
                3: regs = {32'hffffffff, 32'hffffffff, 32'hffffffff,
                           32'hffffffff, 32'hffffffff, 32'hffffffff};
                default:
                begin
                    regs[REG_TIME_STEP] = $urandom_range(32'd2000000, 32'd1);
                    for (int r = 1; r < NUM_REGS; r++)
                        regs[r] = $urandom_range(32'd2000000);
                end
            endcase
            // in phase 4, write a full-range random time step, then the nominal one
            if (ph == 4)
                regs[REG_TIME_STEP] = $urandom;
            write_regs(regs, ph == 0 || ph == 5);
            if (ph == 4)
            begin
                regs[REG_TIME_STEP] = 32'd167772;
                write_regs(regs, 1'b0);
            end

            case (ph % 4)
                0: begin idle_in = 0;  stall_pct = 0;  end
                1: begin idle_in = 49; stall_pct = 0;  end
                2: begin idle_in = 0;  stall_pct = 49; end
                default: begin idle_in = 27; stall_pct = 27; end
            endcase

            for (int n = 0; n < RAND_PER_PHASE; n++)
            begin
                // in phase 4, before every tenth item, hold off until every result is back
                if (ph == 4 && n % 10 == 0)
                    wait_drained();
                send(random_meas(), idle_in);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (errors == 0 && estimate_q.size() == 0)
            $display("kalman_angle_rate_bias_top_tb: done, clean");
        else
            $display("kalman_angle_rate_bias_top_tb: done, errors");
        $finish;
    end

endmodule
